// ===== sv/distance_fade_controller_macros.svh =====
// Assertion macros used by the distance fade controller fade core.
`ifndef DISTANCE_FADE_CONTROLLER_MACROS_SVH
`define DISTANCE_FADE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dfc_pkg.sv =====
// Types and constants of the distance fade controller.
`default_nettype none
package dfc_pkg;

  localparam int LEVEL_W = 5;
  localparam int FadeTimeUs = 500000;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_NEAR     = 2'd0;
  localparam logic [1:0] CFG_FAR      = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;

  // Phase codes as seen on the result item
  localparam logic [2:0] PH_INITIAL  = 3'd0;
  localparam logic [2:0] PH_OUT      = 3'd1;
  localparam logic [2:0] PH_FADE_IN  = 3'd2;
  localparam logic [2:0] PH_IN       = 3'd3;
  localparam logic [2:0] PH_FADE_OUT = 3'd4;

  typedef enum logic [4:0] {
    ST_INITIAL  = 5'b00001,
    ST_OUT      = 5'b00010,
    ST_FADE_IN  = 5'b00100,
    ST_IN       = 5'b01000,
    ST_FADE_OUT = 5'b10000
  } phase_state_t;

  typedef struct packed {
    logic [31:0] distance_sq;
    logic [47:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic [LEVEL_W-1:0] fade_level;
  } out_item_t;

  typedef struct packed {
    logic [31:0] near_limit_sq;
    logic [31:0] far_limit_sq;
    logic [31:0] step_interval_us;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/dfc_cfg_regs.sv =====
// Configuration registers of the distance fade controller.
`default_nettype none
module dfc_cfg_regs #(
  parameter logic [31:0] RESET_INTERVAL = 32'd27777
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output dfc_pkg::cfg_t      cfg
);
  import dfc_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg          = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.near_limit_sq    <= 32'd0;
      regs.far_limit_sq     <= 32'hFFFF_FFFF;
      regs.step_interval_us <= RESET_INTERVAL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEAR:     regs.near_limit_sq    <= cfg_data;
        CFG_FAR:      regs.far_limit_sq     <= cfg_data;
        CFG_INTERVAL: regs.step_interval_us <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/dfc_fade_core.sv =====
// Fade phase machine: range test, level stepping and deadline update.
`default_nettype none
`include "distance_fade_controller_macros.svh"
module dfc_fade_core #(
  parameter int LEVEL_COUNT = 18
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire dfc_pkg::cfg_t     cfg,
  input  wire dfc_pkg::in_item_t item,
  output dfc_pkg::out_item_t     res
);
  import dfc_pkg::*;

  localparam logic [LEVEL_W-1:0] LevelFull     = LEVEL_W'(LEVEL_COUNT - 1);
  localparam logic [LEVEL_W-1:0] LevelFirstOut = LEVEL_W'(LEVEL_COUNT - 2);
  localparam logic [LEVEL_W-1:0] LevelFirstIn  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LevelOut      = '0;

  phase_state_t       phase;
  phase_state_t       phase_next;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [47:0]        next_time;
  logic [47:0]        next_time_next;

  logic               in_range;
  logic               due;
  logic [48:0]        sum;
  logic [47:0]        deadline;
  logic [LEVEL_W:0]   level_inc;

  assign in_range = (cfg.near_limit_sq <= item.distance_sq) &&
                    (item.distance_sq <= cfg.far_limit_sq);
  assign due    = item.now_us >= next_time;
  assign sum    = {1'b0, item.now_us} + {17'd0, cfg.step_interval_us};
  // Saturate the deadline at the top of the time range
  assign deadline  = sum[48] ? TIME_MAX : sum[47:0];
  assign level_inc = {1'b0, level} + {{LEVEL_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next     = phase;
    level_next     = level;
    next_time_next = next_time;
    case (phase)
      ST_OUT: begin
        if (in_range) begin
          phase_next     = ST_FADE_IN;
          level_next     = LevelFirstIn;
          next_time_next = deadline;
        end
      end
      ST_FADE_IN: begin
        if (in_range) begin
          if (due) begin
            if (level_inc >= {1'b0, LevelFull}) begin
              level_next = LevelFull;
              phase_next = ST_IN;
            end else begin
              level_next     = level_inc[LEVEL_W-1:0];
              next_time_next = deadline;
            end
          end
        end else begin
          // Reverse direction, keep the level
          phase_next     = ST_FADE_OUT;
          next_time_next = deadline;
        end
      end
      ST_IN: begin
        if (!in_range) begin
          phase_next     = ST_FADE_OUT;
          level_next     = LevelFirstOut;
          next_time_next = deadline;
        end
      end
      ST_FADE_OUT: begin
        if (!in_range) begin
          if (due) begin
            if (level <= LEVEL_W'(1)) begin
              level_next = LevelOut;
              phase_next = ST_OUT;
            end else begin
              level_next     = level - LEVEL_W'(1);
              next_time_next = deadline;
            end
          end
        end else begin
          phase_next     = ST_FADE_IN;
          next_time_next = deadline;
        end
      end
      default: begin
        if (in_range) begin
          phase_next = ST_IN;
          level_next = LevelFull;
        end else begin
          phase_next = ST_OUT;
          level_next = LevelOut;
        end
      end
    endcase
  end

  always_comb begin
    case (phase_next)
      ST_OUT:      res.phase = PH_OUT;
      ST_FADE_IN:  res.phase = PH_FADE_IN;
      ST_IN:       res.phase = PH_IN;
      ST_FADE_OUT: res.phase = PH_FADE_OUT;
      default:     res.phase = PH_INITIAL;
    endcase
    res.fade_level = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ST_INITIAL;
      level     <= LevelOut;
      next_time <= 48'd0;
    end else if (step) begin
      phase     <= phase_next;
      level     <= level_next;
      next_time <= next_time_next;
    end
  end

  `DFC_ASSERT_IMPL(a_level_range, 1'b1, level <= LevelFull, "fade level above full")
  `DFC_ASSERT_IMPL(a_in_full, phase == ST_IN, level == LevelFull, "in phase without full level")
  `DFC_ASSERT_IMPL(a_out_zero, phase == ST_OUT, level == LevelOut, "out phase with nonzero level")
  `DFC_ASSERT_NEXT(a_hold, !step, $stable(level) && $stable(next_time) && $stable(phase),
    "state moved without an item")

endmodule
`default_nettype wire

// ===== sv/distance_fade_controller.sv =====
// Distance fade controller top level: input register, fade core, result register.
//
// Usage:
//   Input items (in_data: distance_sq, now_us) enter on in_valid/in_stall; an
//   item is taken at a clock edge with in_valid high and in_stall low.
//   Each item yields exactly one result (out_data: phase, fade_level) on
//   out_valid/out_stall, taken when out_valid is high and out_stall low.
//   Configuration (cfg_index 0 near, 1 far, 2 step interval) is written on
//   cfg_valid/cfg_ready; cfg_ready is always high. Write only while idle.
//   A result is formed as its item passes from the input register, through
//   the single-pass fade logic, into the result register.
//   Throughput: one item per cycle while no stall holds the result; the phase,
//   level and deadline registers update in the same cycle that a result is
//   loaded, so the next item sees them at once.
//   Stall: while a result waits, one more item is still taken into the input
//   register; after that in_stall rises until out_stall drops.
//   Reset (rst, synchronous): no items held, phase initial, level 0,
//   deadline 0, near 0, far all ones, interval 500000 / LEVEL_COUNT us.
`default_nettype none
module distance_fade_controller #(
  parameter int LEVEL_COUNT = 18
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dfc_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dfc_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import dfc_pkg::*;

  localparam logic [31:0] ResetInterval = 32'(FadeTimeUs / LEVEL_COUNT);

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  out_item_t res;
  logic      out_advance;
  logic      move;

  assign out_advance = !out_valid || !out_stall;
  assign move        = item_valid && out_advance;
  assign in_stall    = item_valid && !out_advance;

  dfc_cfg_regs #(
    .RESET_INTERVAL(ResetInterval)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  dfc_fade_core #(
    .LEVEL_COUNT(LEVEL_COUNT)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .step(move),
    .cfg (cfg),
    .item(item),
    .res (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire
